// File: rtl/lpr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lpr_pkg;

   // Sizing of the frame table.
   localparam int MAX_FRAMES = 16;
   localparam int PAGE_BITS  = 16;
   localparam int SLOT_BITS  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int AGE_BITS   = SLOT_BITS;
   localparam int CNT_BITS   = $clog2(MAX_FRAMES + 1);

   // Fixed widths of the port fields.
   localparam int PAGE_FIELD_BITS = 16;
   localparam int SLOT_FIELD_BITS = 4;
   localparam int MISS_BITS       = 16;
   localparam int CFG_BITS        = 5;
   localparam int CMP_BITS        = (CNT_BITS > CFG_BITS) ? CNT_BITS : CFG_BITS;

   localparam logic [CFG_BITS-1:0]  CFG_RESET = CFG_BITS'(16);
   localparam logic [AGE_BITS-1:0]  AGE_MAX   = AGE_BITS'(MAX_FRAMES - 1);
   localparam logic [AGE_BITS:0]    LIMIT_ALL = (AGE_BITS + 1)'(MAX_FRAMES);
   localparam logic [MISS_BITS-1:0] MISS_MAX  = '1;

   typedef logic [PAGE_BITS-1:0]  page_type;
   typedef logic [SLOT_BITS-1:0]  slot_type;
   typedef logic [AGE_BITS-1:0]   age_type;
   typedef logic [MAX_FRAMES-1:0] frame_mask_type;

   // Outcome of one lookup in the frame table.
   typedef struct packed {
      logic     hit;
      slot_type slot;
      logic     evicted_valid;
      page_type evicted_page;
   } lpr_lookup_type;

   // Index of the lowest set bit; zero when no bit is set.
   function automatic slot_type lowest_set(input frame_mask_type v);
      slot_type r;
      r = '0;
      for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
         if (v[i]) begin
            r = SLOT_BITS'(i);
         end
      end
      return r;
   endfunction

   // Frames below the programmed count, with zero read as one and the
   // count clamped to the table size.
   function automatic frame_mask_type active_mask(input logic [CFG_BITS-1:0] cfg);
      logic [CMP_BITS-1:0] n;
      frame_mask_type      m;
      n = CMP_BITS'(cfg);
      if (n == '0) begin
         n = CMP_BITS'(1);
      end
      if (n > CMP_BITS'(MAX_FRAMES)) begin
         n = CMP_BITS'(MAX_FRAMES);
      end
      for (int i = 0; i < MAX_FRAMES; i++) begin
         m[i] = CMP_BITS'(i) < n;
      end
      return m;
   endfunction

   // Reduce or widen a port page number to the stored page width.
   function automatic page_type page_of(input logic [PAGE_FIELD_BITS-1:0] p);
      return PAGE_BITS'(p);
   endfunction

endpackage

`default_nettype wire

// File: rtl/lru_page_replacement.sv
`timescale 1ns / 1ps
`default_nettype none

// LRU page replacement unit.
// Page references arrive on the req_ channel, one item per reference, and
// each produces exactly one item on the rsp_ channel: hit flag, frame slot,
// evicted page (zero when nothing was evicted) and a saturating miss count.
// An accepted item sits in an input register while the frame compare,
// victim choice and recency update run across all frames in parallel;
// the result register and the frame table load at the same edge.
// Each item passes the input register and then the result register, and
// one item is taken every cycle while the result side does not stall,
// since each lookup sees the table as left by the item before it.
// csr_wr_en writes the frame count; write it only while no item is in
// flight. Reset empties all frames, clears the miss count and sets the
// frame count to 16. While rsp_stall holds a result, one more item is
// taken into the input register, after which req_stall rises until the
// result is taken.
module lru_page_replacement import lpr_pkg::*; (
   input  var logic                       clock,
   input  var logic                       reset,
   input  var logic                       req_valid,
   output var logic                       req_stall,
   input  var logic [PAGE_FIELD_BITS-1:0] req_page_number,
   output var logic                       rsp_valid,
   input  var logic                       rsp_stall,
   output var logic                       rsp_hit,
   output var logic [SLOT_FIELD_BITS-1:0] rsp_frame_slot,
   output var logic                       rsp_evicted_valid,
   output var logic [PAGE_FIELD_BITS-1:0] rsp_evicted_page,
   output var logic [MISS_BITS-1:0]       rsp_miss_count,
   input  var logic                       csr_wr_en,
   input  var logic [CFG_BITS-1:0]        csr_wr_data
);

   logic [CFG_BITS-1:0]  frames_in_use_ff;
   logic                 in_valid_ff;
   page_type             in_page_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_hit_ff;
   slot_type             rsp_slot_ff;
   logic                 rsp_evicted_valid_ff;
   page_type             rsp_evicted_page_ff;
   logic [MISS_BITS-1:0] miss_count_ff;
   logic [MISS_BITS-1:0] miss_count_in;

   logic           advance;
   logic           process;
   frame_mask_type active;
   lpr_lookup_type lookup;

   // Handshake: the result register moves when empty or taken.
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign process   = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   // Frame count register.
   always_ff @(posedge clock) begin
      if (reset) begin
         frames_in_use_ff <= CFG_RESET;
      end else if (csr_wr_en) begin
         frames_in_use_ff <= csr_wr_data;
      end
   end

   assign active = active_mask(frames_in_use_ff);

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!in_valid_ff || advance) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_page_ff <= page_of(req_page_number);
      end
   end

   lpr_frame_table u_table (
      .clock       (clock),
      .reset       (reset),
      .active      (active),
      .lookup_page (in_page_ff),
      .update_en   (process),
      .lookup      (lookup)
   );

   // Saturating miss counter.
   always_comb begin
      miss_count_in = miss_count_ff;
      if (!lookup.hit && (miss_count_ff != MISS_MAX)) begin
         miss_count_in = miss_count_ff + MISS_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         miss_count_ff <= '0;
      end else if (process) begin
         miss_count_ff <= miss_count_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (process) begin
         rsp_hit_ff           <= lookup.hit;
         rsp_slot_ff          <= lookup.slot;
         rsp_evicted_valid_ff <= lookup.evicted_valid;
         rsp_evicted_page_ff  <= lookup.evicted_page;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_frame_slot    = SLOT_FIELD_BITS'(rsp_slot_ff);
   assign rsp_evicted_valid = rsp_evicted_valid_ff;
   assign rsp_evicted_page  = PAGE_FIELD_BITS'(rsp_evicted_page_ff);
   assign rsp_miss_count    = miss_count_ff;

   // A hit never evicts.
   a_hit_no_evict : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_hit_ff |-> !rsp_evicted_valid_ff)
      else $error("hit reported together with an eviction");

   // The evicted page reads zero when nothing was evicted.
   a_evict_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_evicted_valid_ff |-> (rsp_evicted_page_ff == '0))
      else $error("evicted page nonzero without an eviction");

   // The miss count moves only when a missing item is finished.
   a_miss_step : assert property (@(posedge clock) disable iff (reset)
      !(process && !lookup.hit) |=> $stable(miss_count_ff))
      else $error("miss count changed without a miss");

   a_miss_up : assert property (@(posedge clock) disable iff (reset)
      process && !lookup.hit && (miss_count_ff != MISS_MAX)
      |=> miss_count_ff == $past(miss_count_ff) + MISS_BITS'(1))
      else $error("miss count did not advance on a miss");

endmodule

`default_nettype wire

// File: rtl/lpr_victim_select.sv
`timescale 1ns / 1ps
`default_nettype none

module lpr_victim_select import lpr_pkg::*; (
   input  var age_type [MAX_FRAMES-1:0] ages,
   input  var frame_mask_type           active,
   output var slot_type                 victim
);

   frame_mask_type is_max;

   // A frame wins when no active frame is older, and no lower active frame
   // is equally old. All pairs are compared side by side.
   always_comb begin
      for (int i = 0; i < MAX_FRAMES; i++) begin
         is_max[i] = active[i];
         for (int j = 0; j < MAX_FRAMES; j++) begin
            if (active[j] && (j != i)) begin
               if (j < i) begin
                  if (ages[j] >= ages[i]) begin
                     is_max[i] = 1'b0;
                  end
               end else begin
                  if (ages[j] > ages[i]) begin
                     is_max[i] = 1'b0;
                  end
               end
            end
         end
      end
   end

   assign victim = lowest_set(is_max);

endmodule

`default_nettype wire

// File: rtl/lpr_frame_table.sv
`timescale 1ns / 1ps
`default_nettype none

module lpr_frame_table import lpr_pkg::*; (
   input  var logic           clock,
   input  var logic           reset,
   input  var frame_mask_type active,
   input  var page_type       lookup_page,
   input  var logic           update_en,
   output var lpr_lookup_type lookup
);

   page_type                 frame_page_ff [MAX_FRAMES];
   frame_mask_type           frame_valid_ff;
   age_type [MAX_FRAMES-1:0] frame_age_ff;

   frame_mask_type match;
   frame_mask_type empty;
   slot_type       hit_slot;
   slot_type       empty_slot;
   slot_type       victim_slot;
   slot_type       slot;
   logic           hit;
   logic           any_empty;
   logic [AGE_BITS:0] limit;

   // Parallel compare of the page against every active valid frame.
   always_comb begin
      for (int i = 0; i < MAX_FRAMES; i++) begin
         match[i] = active[i] && frame_valid_ff[i] && (frame_page_ff[i] == lookup_page);
         empty[i] = active[i] && !frame_valid_ff[i];
      end
   end

   assign hit        = |match;
   assign any_empty  = |empty;
   assign hit_slot   = lowest_set(match);
   assign empty_slot = lowest_set(empty);

   lpr_victim_select u_victim (
      .ages   (frame_age_ff),
      .active (active),
      .victim (victim_slot)
   );

   // Pick the frame used by this item and the age bound for the others.
   always_comb begin
      if (hit) begin
         slot  = hit_slot;
         limit = {1'b0, frame_age_ff[hit_slot]};
      end else if (any_empty) begin
         slot  = empty_slot;
         limit = LIMIT_ALL;
      end else begin
         slot  = victim_slot;
         limit = LIMIT_ALL;
      end
      lookup.hit           = hit;
      lookup.slot          = slot;
      lookup.evicted_valid = !hit && !any_empty;
      lookup.evicted_page  = (!hit && !any_empty) ? frame_page_ff[victim_slot] : '0;
   end

   // Page numbers are written only on a miss and read only while valid.
   always_ff @(posedge clock) begin
      if (update_en && !hit) begin
         frame_page_ff[slot] <= lookup_page;
      end
   end

   // Valid flags and recency ranks.
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_valid_ff <= '0;
         frame_age_ff   <= '0;
      end else if (update_en) begin
         for (int i = 0; i < MAX_FRAMES; i++) begin
            if (SLOT_BITS'(i) == slot) begin
               frame_valid_ff[i] <= 1'b1;
               frame_age_ff[i]   <= '0;
            end else if (active[i] && frame_valid_ff[i]
                         && ({1'b0, frame_age_ff[i]} < limit)
                         && (frame_age_ff[i] < AGE_MAX)) begin
               frame_age_ff[i] <= frame_age_ff[i] + AGE_BITS'(1);
            end
         end
      end
   end

   // The frame just used is valid and most recent afterwards.
   a_used_frame_fresh : assert property (@(posedge clock) disable iff (reset)
      update_en |=> frame_valid_ff[$past(slot)] && (frame_age_ff[$past(slot)] == '0))
      else $error("used frame is not valid and most recent");

   // A hit only ever comes from an active frame.
   a_hit_active : assert property (@(posedge clock) disable iff (reset)
      hit |-> active[hit_slot] && frame_valid_ff[hit_slot])
      else $error("hit on an inactive or empty frame");

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import lpr_pkg::*;

   // One result item as it leaves the block.
   typedef struct packed {
      logic                       hit;
      logic [SLOT_FIELD_BITS-1:0] frame_slot;
      logic                       evicted_valid;
      logic [PAGE_FIELD_BITS-1:0] evicted_page;
      logic [MISS_BITS-1:0]       miss_count;
   } frame_result_type;

   // Ways the result side can hold off the block.
   typedef enum int {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_mode_type;

   // Tracks the frame table and queues the result each reference should give.
   class lru_frame_model_type;
      logic [CFG_BITS-1:0]  frames_in_use;
      page_type             frame_page [MAX_FRAMES];
      bit                   frame_valid [MAX_FRAMES];
      age_type              frame_age [MAX_FRAMES];
      logic [MISS_BITS-1:0] misses_seen;
      frame_result_type     expected_results [$];
      int unsigned          error_count;

      function new();
         frames_in_use = CFG_RESET;
         misses_seen   = '0;
         error_count   = 0;
         foreach (frame_valid[i]) begin
            frame_page[i]  = '0;
            frame_valid[i] = 1'b0;
            frame_age[i]   = '0;
         end
      endfunction

      // Make frame f the most recent; valid frames younger than limit age by one.
      function void promote(int n, int f, int limit);
         for (int i = 0; i < n; i++) begin
            if (i != f && frame_valid[i] && int'(frame_age[i]) < limit &&
                frame_age[i] < AGE_MAX) begin
               frame_age[i] = frame_age[i] + 1'b1;
            end
         end
         frame_age[f] = '0;
      endfunction

      function void note_reference(logic [PAGE_FIELD_BITS-1:0] page_in);
         page_type         page;
         int               n;
         int               slot;
         bit               found;
         bit               empty;
         age_type          oldest;
         frame_result_type r;
         page  = page_type'(page_in);
         r     = '0;
         slot  = 0;
         found = 1'b0;
         empty = 1'b0;
         // A zero count acts as one frame, a large count as the whole table.
         n = int'(frames_in_use);
         if (n == 0) begin
            n = 1;
         end
         if (n > MAX_FRAMES) begin
            n = MAX_FRAMES;
         end
         for (int i = 0; i < n && !found; i++) begin
            if (frame_valid[i] && frame_page[i] == page) begin
               slot  = i;
               found = 1'b1;
            end
         end
         if (found) begin
            r.hit = 1'b1;
            promote(n, slot, int'(frame_age[slot]));
         end else begin
            for (int i = 0; i < n && !empty; i++) begin
               if (!frame_valid[i]) begin
                  slot  = i;
                  empty = 1'b1;
               end
            end
            // With no empty frame, the oldest one goes; ties go to the lowest index.
            if (!empty) begin
               oldest = '0;
               slot   = 0;
               for (int i = 0; i < n; i++) begin
                  if (frame_age[i] > oldest) begin
                     oldest = frame_age[i];
                     slot   = i;
                  end
               end
               r.evicted_valid = 1'b1;
               r.evicted_page  = PAGE_FIELD_BITS'(frame_page[slot]);
            end
            frame_page[slot]  = page;
            frame_valid[slot] = 1'b1;
            promote(n, slot, MAX_FRAMES);
            if (misses_seen != MISS_MAX) begin
               misses_seen = misses_seen + 1'b1;
            end
         end
         r.frame_slot = SLOT_FIELD_BITS'(slot);
         r.miss_count = misses_seen;
         expected_results.push_back(r);
      endfunction

      function int pending();
         return expected_results.size();
      endfunction

      function void compare_field(string name, logic [31:0] want_v, logic [31:0] got_v);
         if (got_v !== want_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
            error_count++;
         end
      endfunction

      function void check_result(frame_result_type got);
         frame_result_type want;
         if (expected_results.size() == 0) begin
            $error("result item arrived with no reference outstanding");
            error_count++;
            return;
         end
         want = expected_results.pop_front();
         compare_field("hit", 32'(want.hit), 32'(got.hit));
         compare_field("frame_slot", 32'(want.frame_slot), 32'(got.frame_slot));
         compare_field("evicted_valid", 32'(want.evicted_valid), 32'(got.evicted_valid));
         compare_field("evicted_page", 32'(want.evicted_page), 32'(got.evicted_page));
         compare_field("miss_count", 32'(want.miss_count), 32'(got.miss_count));
      endfunction
   endclass

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [PAGE_FIELD_BITS-1:0] req_page_number = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic                       rsp_hit;
   logic [SLOT_FIELD_BITS-1:0] rsp_frame_slot;
   logic                       rsp_evicted_valid;
   logic [PAGE_FIELD_BITS-1:0] rsp_evicted_page;
   logic [MISS_BITS-1:0]       rsp_miss_count;
   logic                       csr_wr_en = 1'b0;
   logic [CFG_BITS-1:0]        csr_wr_data = '0;

   lru_frame_model_type frame_model = new();
   int                  burst_left = 0;
   int                  stall_left = 0;
   int                  stall_phase = 0;
   stall_mode_type      stall_mode = STALL_NONE;

   lru_page_replacement dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_page_number   (req_page_number),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_hit           (rsp_hit),
      .rsp_frame_slot    (rsp_frame_slot),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_page  (rsp_evicted_page),
      .rsp_miss_count    (rsp_miss_count),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   always #2 clock = ~clock;

   // Both channels are sampled at the rising edge; results are checked first.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            frame_model.check_result('{rsp_hit, rsp_frame_slot, rsp_evicted_valid,
                                       rsp_evicted_page, rsp_miss_count});
         end
         if (req_valid && !req_stall) begin
            frame_model.note_reference(req_page_number);
         end
      end
   end

   // The result side switches at random between stall patterns.
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         stall_left = $urandom_range(16, 200);
      end
      stall_left--;
      stall_phase++;
      case (stall_mode)
         STALL_NONE: begin
            rsp_stall <= 1'b0;
         end
         STALL_LIGHT: begin
            rsp_stall <= ($urandom_range(0, 3) == 0);
         end
         STALL_HEAVY: begin
            rsp_stall <= ($urandom_range(0, 3) != 0);
         end
         default: begin
            rsp_stall <= (stall_phase % 5 < 2);
         end
      endcase
   end

   // Present one page reference and hold it until it is taken. References go
   // out in bursts, often with idle gaps in between.
   task automatic send_page(input logic [PAGE_FIELD_BITS-1:0] page);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid       <= 1'b1;
      req_page_number <= page;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Change the frame count once every outstanding item has come back.
   task automatic set_frame_count(input logic [CFG_BITS-1:0] value);
      @(negedge clock);
      req_valid <= 1'b0;
      burst_left = 0;
      while (frame_model.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      frame_model.frames_in_use = value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Random references, mostly drawn from a working set the size of the active
   // frames or a little larger, so that hits and evictions both happen often.
   task automatic run_random_phase(input int count);
      logic [PAGE_FIELD_BITS-1:0] base;
      logic [PAGE_FIELD_BITS-1:0] last_page;
      logic [PAGE_FIELD_BITS-1:0] page;
      int                         n;
      int                         set_size;
      int                         roll;
      base = PAGE_FIELD_BITS'($urandom());
      last_page = base;
      n = int'(frame_model.frames_in_use);
      n = (n == 0) ? 1 : ((n > MAX_FRAMES) ? MAX_FRAMES : n);
      set_size = n + $urandom_range(0, 4);
      for (int k = 0; k < count; k++) begin
         roll = $urandom_range(0, 99);
         if (roll < 65) begin
            page = base + PAGE_FIELD_BITS'($urandom_range(0, set_size - 1));
         end else if (roll < 80) begin
            page = last_page;
         end else begin
            page = PAGE_FIELD_BITS'($urandom());
         end
         send_page(page);
         last_page = page;
      end
   endtask

   initial begin
      logic [CFG_BITS-1:0] phase_counts [11];
      phase_counts = '{5'd16, 5'd1, 5'd0, 5'd4, 5'd31, 5'd2, 5'd16, 5'd8, 5'd3, 5'd17, 5'd16};

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Cold fills at the reset count, a hit, and the page extremes.
      send_page(16'h0000);
      send_page(16'hFFFF);
      send_page(16'h0000);
      send_page(16'h8001);
      send_page(16'h7FFE);
      send_page(16'h5555);
      send_page(16'hAAAA);
      send_page(16'hFFFF);

      // Shrinking the count hides the upper frames; misses now evict.
      set_frame_count(5'd3);
      send_page(16'h1234);
      send_page(16'h5555);
      send_page(16'h0000);
      send_page(16'h8001);

      // A zero count behaves as a single frame.
      set_frame_count(5'd0);
      send_page(16'h1111);
      send_page(16'h1111);
      send_page(16'h2222);

      // A count above the table size uses every frame; hidden pages return.
      set_frame_count(5'd31);
      send_page(16'h7FFE);
      send_page(16'hAAAA);
      for (int k = 0; k < 6; k++) begin
         send_page(16'h4000 + PAGE_FIELD_BITS'(k));
      end

      foreach (phase_counts[p]) begin
         set_frame_count(phase_counts[p]);
         run_random_phase($urandom_range(64, 80));
      end

      set_frame_count(5'd16);
      run_random_phase(60);

      @(negedge clock);
      req_valid <= 1'b0;
      while (frame_model.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (frame_model.error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #20000000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
